// ===== hdl/mwur_pkg.sv =====
// ----------------------------------------------------------------------------
// mwur_pkg
// Shared types and constants of the maze wall union relabel core.
// ----------------------------------------------------------------------------
package mwur_pkg;

   localparam int MAX_SIDE    = 63;
   localparam int SIDE_W      = 6;
   localparam int HALF_W      = 5;
   localparam int LABEL_W     = 10;
   localparam int LABEL_DEPTH = 1 << LABEL_W;
   localparam int ROW_DEPTH   = 1 << SIDE_W;
   localparam int MIN_SIDE    = 5;

   // command codes
   localparam logic [1:0] CMD_START = 2'd0;
   localparam logic [1:0] CMD_OFFER = 2'd1;
   localparam logic [1:0] CMD_READ  = 2'd2;

   typedef logic [SIDE_W-1:0]  coord_type;
   typedef logic [LABEL_W-1:0] label_type;

   typedef enum logic [9:0] {
      S_IDLE   = 10'b00_0000_0001,
      S_DECODE = 10'b00_0000_0010,
      S_RDA    = 10'b00_0000_0100,
      S_RDB    = 10'b00_0000_1000,
      S_CMP    = 10'b00_0001_0000,
      S_SCAN   = 10'b00_0010_0000,
      S_CLEAR  = 10'b00_0100_0000,
      S_WREAD  = 10'b00_1000_0000,
      S_WBIT   = 10'b01_0000_0000,
      S_RESP   = 10'b10_0000_0000
   } state_type;

endpackage

// ===== hdl/mwur_req_if.sv =====
// ----------------------------------------------------------------------------
// mwur_req_if
// Command channel: valid/ready plus command, row and column.
// ----------------------------------------------------------------------------
interface mwur_req_if
   import mwur_pkg::*;
   ;
   logic       valid;
   logic       ready;
   logic [1:0] command;
   coord_type  row;
   coord_type  column;

   modport source (output valid, output command, output row, output column, input ready);
   modport sink   (input valid, input command, input row, input column, output ready);
endinterface

// ===== hdl/mwur_rsp_if.sv =====
// ----------------------------------------------------------------------------
// mwur_rsp_if
// Result channel: valid/ready plus the four status bits.
// ----------------------------------------------------------------------------
interface mwur_rsp_if;
   logic valid;
   logic ready;
   logic wall_opened;
   logic finished;
   logic rejected;
   logic position_open;

   modport source (output valid, output wall_opened, output finished, output rejected,
                   output position_open, input ready);
   modport sink   (input valid, input wall_opened, input finished, input rejected,
                   input position_open, output ready);
endinterface

// ===== hdl/mwur_csr_if.sv =====
// ----------------------------------------------------------------------------
// mwur_csr_if
// Register write channel: valid/ready plus the grid side value.
// ----------------------------------------------------------------------------
interface mwur_csr_if
   import mwur_pkg::*;
   ;
   logic      valid;
   logic      ready;
   coord_type grid_side;

   modport source (output valid, output grid_side, input ready);
   modport sink   (input valid, input grid_side, output ready);
endinterface

// ===== hdl/maze_wall_union_relabel_core.sv =====
// ----------------------------------------------------------------------------
// maze_wall_union_relabel_core
// Randomized Kruskal maze builder with union by relabeling. A start
// transaction numbers every cell of the grid and clears all walls in a
// sweep over max(cells, 64) label memory entries (one label and one wall
// row written per cycle), where cells = ((side-1)/2)^2, 961 at the default
// side of 63. An offer reads the labels of the two cells beside the wall
// and ends when they already match; else the wall opens and a relabel scan
// runs over all cells through the label memory's separate read and write
// ports (one read and one conditional write per cycle, pipelined). A read
// of a cell or port needs no memory; a rejected offer or read and an illegal
// command go straight to the result. One transaction is worked at a time;
// req ready is high only while the sequencer is idle, and the result sits
// in an output register so the next transaction may be accepted before the
// previous result is taken. Writing grid_side drops the started flag, so a
// new start must follow before offers or reads are accepted as legal;
// grid_side writes are taken only while the sequencer is idle.
// ----------------------------------------------------------------------------
module maze_wall_union_relabel_core
   import mwur_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   mwur_req_if.sink   req_ch,
   mwur_rsp_if.source rsp_ch,
   mwur_csr_if.sink   csr_ch
);

   // ---------------------------------------------------------------------
   // state
   // ---------------------------------------------------------------------
   state_type       state_ff, state_in;
   logic [1:0]      cmd_ff, cmd_in;
   coord_type       row_ff, row_in;
   coord_type       col_ff, col_in;
   coord_type       grid_side_ff, grid_side_in;
   logic            started_ff, started_in;
   label_type       comp_ff, comp_in;
   label_type       cells_ff;
   label_type       prod_ff, prod_in;
   logic [HALF_W-1:0] cola_ff, cola_in;
   logic            vert_ff, vert_in;
   label_type       la_ff, la_in;
   label_type       lb_ff, lb_in;
   label_type       k_ff, k_in;
   logic            p_vld_ff, p_vld_in;
   label_type       p_idx_ff, p_idx_in;
   logic            res_opened_ff, res_opened_in;
   logic            res_rej_ff, res_rej_in;
   logic            res_popen_ff, res_popen_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic            rsp_opened_ff, rsp_opened_in;
   logic            rsp_fin_ff, rsp_fin_in;
   logic            rsp_rej_ff, rsp_rej_in;
   logic            rsp_popen_ff, rsp_popen_in;

   // memories
   label_type              lab_mem [LABEL_DEPTH];
   logic [ROW_DEPTH-1:0]   wall_mem [ROW_DEPTH];
   label_type              lab_rd_ff;
   logic [ROW_DEPTH-1:0]   wall_rd_ff;

   // memory controls
   logic       lab_we;
   label_type  lab_waddr;
   label_type  lab_wdata;
   label_type  lab_raddr;
   logic       wall_clr;
   logic       wall_set;
   coord_type  wall_row;

   // ---------------------------------------------------------------------
   // grid geometry: effective odd side, half side and cell count
   // ---------------------------------------------------------------------
   coord_type         side;
   logic [HALF_W-1:0] half;
   label_type         cells_calc;

   always_comb begin
      side = grid_side_ff;
      if (!side[0] && side != '0) begin
         side = side - SIDE_W'(1);
      end
      if (side < SIDE_W'(MIN_SIDE)) begin
         side = SIDE_W'(MIN_SIDE);
      end
   end

   assign half       = side[SIDE_W-1:1];
   assign cells_calc = label_type'(half) * label_type'(half);

   // ---------------------------------------------------------------------
   // decode helpers (from the captured transaction)
   // ---------------------------------------------------------------------
   coord_type         side_m1, side_m2;
   logic              offer_bad, read_bad, is_cell, is_port;
   logic [HALF_W-1:0] rowsel;
   label_type         prod_calc;
   label_type         clr_last;
   label_type         idx_b;

   assign side_m1   = side - SIDE_W'(1);
   assign side_m2   = side - SIDE_W'(2);
   // a wall has exactly one odd coordinate, strictly inside the border
   assign offer_bad = !started_ff || row_ff == '0 || col_ff == '0 ||
                      row_ff > side_m2 || col_ff > side_m2 || row_ff[0] == col_ff[0];
   assign read_bad  = !started_ff || row_ff >= side || col_ff >= side;
   assign is_cell   = row_ff[0] & col_ff[0];
   // entrance and exit
   assign is_port   = (row_ff == SIDE_W'(1) && col_ff == '0) ||
                      (row_ff == side_m2 && col_ff == side_m1);
   // even row: cells above and below; odd row: cells left and right
   assign rowsel    = row_ff[0] ? row_ff[SIDE_W-1:1] : row_ff[SIDE_W-1:1] - HALF_W'(1);
   assign prod_calc = label_type'(rowsel) * label_type'(half);
   assign clr_last  = (cells_ff < label_type'(ROW_DEPTH)) ? label_type'(ROW_DEPTH - 1)
                                                          : cells_ff - label_type'(1);
   assign idx_b     = vert_ff ? prod_ff + label_type'(half) + label_type'(cola_ff)
                              : prod_ff + label_type'(cola_ff) + label_type'(1);

   // ---------------------------------------------------------------------
   // sequencer
   // ---------------------------------------------------------------------
   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      row_in        = row_ff;
      col_in        = col_ff;
      grid_side_in  = grid_side_ff;
      started_in    = started_ff;
      comp_in       = comp_ff;
      prod_in       = prod_ff;
      cola_in       = cola_ff;
      vert_in       = vert_ff;
      la_in         = la_ff;
      lb_in         = lb_ff;
      k_in          = k_ff;
      p_vld_in      = p_vld_ff;
      p_idx_in      = p_idx_ff;
      res_opened_in = res_opened_ff;
      res_rej_in    = res_rej_ff;
      res_popen_in  = res_popen_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_opened_in = rsp_opened_ff;
      rsp_fin_in    = rsp_fin_ff;
      rsp_rej_in    = rsp_rej_ff;
      rsp_popen_in  = rsp_popen_ff;
      lab_we        = 1'b0;
      lab_waddr     = k_ff;
      lab_wdata     = k_ff + label_type'(1);
      lab_raddr     = k_ff;
      wall_clr      = 1'b0;
      wall_set      = 1'b0;
      wall_row      = row_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_ch.valid) begin
               cmd_in   = req_ch.command;
               row_in   = req_ch.row;
               col_in   = req_ch.column;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            res_opened_in = 1'b0;
            res_rej_in    = 1'b0;
            res_popen_in  = 1'b0;
            unique case (cmd_ff)
               CMD_START: begin
                  k_in     = '0;
                  state_in = S_CLEAR;
               end
               CMD_OFFER: begin
                  if (offer_bad) begin
                     res_rej_in = 1'b1;
                     state_in   = S_RESP;
                  end else begin
                     prod_in  = prod_calc;
                     vert_in  = !row_ff[0];
                     cola_in  = row_ff[0] ? col_ff[SIDE_W-1:1] - HALF_W'(1)
                                          : col_ff[SIDE_W-1:1];
                     state_in = S_RDA;
                  end
               end
               CMD_READ: begin
                  if (read_bad) begin
                     res_rej_in = 1'b1;
                     state_in   = S_RESP;
                  end else if (is_cell || is_port) begin
                     res_popen_in = 1'b1;
                     state_in     = S_RESP;
                  end else begin
                     state_in = S_WREAD;
                  end
               end
               default: begin
                  res_rej_in = 1'b1;
                  state_in   = S_RESP;
               end
            endcase
         end
         S_RDA: begin
            lab_raddr = prod_ff + label_type'(cola_ff);
            state_in  = S_RDB;
         end
         S_RDB: begin
            lab_raddr = idx_b;
            la_in     = lab_rd_ff;
            state_in  = S_CMP;
         end
         S_CMP: begin
            if (la_ff != lab_rd_ff) begin
               lb_in         = lab_rd_ff;
               wall_set      = 1'b1;
               res_opened_in = 1'b1;
               if (comp_ff != '0) begin
                  comp_in = comp_ff - label_type'(1);
               end
               k_in     = '0;
               p_vld_in = 1'b0;
               state_in = S_SCAN;
            end else begin
               state_in = S_RESP;
            end
         end
         S_SCAN: begin
            // read k; write back k-1, whose label was read in the cycle before
            if (k_ff < cells_ff) begin
               lab_raddr = k_ff;
               k_in      = k_ff + label_type'(1);
               p_vld_in  = 1'b1;
               p_idx_in  = k_ff;
            end else begin
               p_vld_in = 1'b0;
            end
            if (p_vld_ff && lab_rd_ff == lb_ff) begin
               lab_we    = 1'b1;
               lab_waddr = p_idx_ff;
               lab_wdata = la_ff;
            end
            if (k_ff >= cells_ff && !p_vld_ff) begin
               state_in = S_RESP;
            end
         end
         S_CLEAR: begin
            lab_we   = 1'b1;
            wall_clr = (k_ff < label_type'(ROW_DEPTH));
            wall_row = k_ff[SIDE_W-1:0];
            if (k_ff == clr_last) begin
               started_in = 1'b1;
               comp_in    = cells_ff;
               state_in   = S_RESP;
            end else begin
               k_in = k_ff + label_type'(1);
            end
         end
         S_WREAD: begin
            state_in = S_WBIT;
         end
         S_WBIT: begin
            res_popen_in = wall_rd_ff[col_ff];
            state_in     = S_RESP;
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_opened_in = res_opened_ff;
               rsp_fin_in    = started_ff && comp_ff == label_type'(1);
               rsp_rej_in    = res_rej_ff;
               rsp_popen_in  = res_popen_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // register write: only while idle
      if (csr_ch.valid && csr_ch.ready) begin
         grid_side_in = csr_ch.grid_side;
         started_in   = 1'b0;
      end
   end

   // ---------------------------------------------------------------------
   // control registers
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         grid_side_ff <= SIDE_W'(MAX_SIDE);
         started_ff   <= 1'b0;
         comp_ff      <= '0;
         p_vld_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         grid_side_ff <= grid_side_in;
         started_ff   <= started_in;
         comp_ff      <= comp_in;
         p_vld_ff     <= p_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      row_ff        <= row_in;
      col_ff        <= col_in;
      cells_ff      <= cells_calc;
      prod_ff       <= prod_in;
      cola_ff       <= cola_in;
      vert_ff       <= vert_in;
      la_ff         <= la_in;
      lb_ff         <= lb_in;
      k_ff          <= k_in;
      p_idx_ff      <= p_idx_in;
      res_opened_ff <= res_opened_in;
      res_rej_ff    <= res_rej_in;
      res_popen_ff  <= res_popen_in;
      rsp_opened_ff <= rsp_opened_in;
      rsp_fin_ff    <= rsp_fin_in;
      rsp_rej_ff    <= rsp_rej_in;
      rsp_popen_ff  <= rsp_popen_in;
   end

   // ---------------------------------------------------------------------
   // label memory: one write, one registered read per cycle
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (lab_we) begin
         lab_mem[lab_waddr] <= lab_wdata;
      end
      lab_rd_ff <= lab_mem[lab_raddr];
   end

   // wall memory: one grid row per word, cleared a row per cycle on start
   always_ff @(posedge clock) begin
      if (wall_clr) begin
         wall_mem[wall_row] <= '0;
      end else if (wall_set) begin
         wall_mem[wall_row][col_ff] <= 1'b1;
      end
      wall_rd_ff <= wall_mem[wall_row];
   end

   // ---------------------------------------------------------------------
   // ports
   // ---------------------------------------------------------------------
   assign req_ch.ready         = (state_ff == S_IDLE);
   assign csr_ch.ready         = (state_ff == S_IDLE);
   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.wall_opened   = rsp_opened_ff;
   assign rsp_ch.finished      = rsp_fin_ff;
   assign rsp_ch.rejected      = rsp_rej_ff;
   assign rsp_ch.position_open = rsp_popen_ff;

endmodule

// ===== hdl/mwur_checker.sv =====
// ----------------------------------------------------------------------------
// mwur_checker
// Port-level assertions for the maze wall union relabel core.
// ----------------------------------------------------------------------------
module mwur_checker
   import mwur_pkg::*;
(
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_wall_opened,
   input logic rsp_finished,
   input logic rsp_rejected,
   input logic rsp_position_open
);

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_wall_opened) &&
      $stable(rsp_finished) && $stable(rsp_rejected) && $stable(rsp_position_open))
      else $error("result changed while stalled");

   // one transaction at a time
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("ready stayed high after accept");

   a_opened_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_wall_opened |-> !rsp_rejected && !rsp_position_open)
      else $error("opened wall flagged with rejected or open position");

   a_popen_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_position_open |-> !rsp_rejected)
      else $error("open position on rejected transaction");

endmodule

bind maze_wall_union_relabel_core mwur_checker u_mwur_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_ch.valid),
   .req_ready         (req_ch.ready),
   .rsp_valid         (rsp_ch.valid),
   .rsp_ready         (rsp_ch.ready),
   .rsp_wall_opened   (rsp_ch.wall_opened),
   .rsp_finished      (rsp_ch.finished),
   .rsp_rejected      (rsp_ch.rejected),
   .rsp_position_open (rsp_ch.position_open)
);
